[rtl/trsd_pkg.sv]
// shared types and constants for the run-length scanline decoder
// no dependencies
`timescale 1ns / 1ps

package trsd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned RUN_W   = 8;
   localparam int unsigned DIM_W   = 16;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned IDX_W   = 2;
   localparam int unsigned RSP_DATA_W = 40;

   // register indexes
   localparam logic [IDX_W-1:0] REG_PIXEL_BYTES = 2'd0;
   localparam logic [IDX_W-1:0] REG_LINE_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] REG_LINE_COUNT  = 2'd2;
   localparam logic [IDX_W-1:0] REG_RLE_ENABLED = 2'd3;

   // packet phase codes
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_RUN    = 2'd1;
   localparam logic [1:0] PH_LIT    = 2'd2;

   localparam logic [BYTE_W-1:0] HDR_RUN_BIAS = 8'd127;

   typedef struct packed {
      logic [2:0]       pixel_bytes;
      logic [DIM_W-1:0] line_width;
      logic [DIM_W-1:0] line_count;
      logic             rle_enabled;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [RUN_W-1:0]   run_length;
      logic               line_end;
      logic               image_end;
   } rsp_type;

endpackage

[rtl/tga_rle_scanline_decoder_unit.sv]
// top level of the run-length scanline decoder
// depends on trsd_pkg, trsd_csr and trsd_decode
`timescale 1ns / 1ps

// Payload bytes enter on the req_ stream, one byte per transaction. In
// run-length mode a header byte sets up a repeat or literal packet; pixel
// bytes are gathered (3 or 4 per pixel) and each finished pixel leaves on
// the rsp_ stream as one transaction carrying the pixel, its run length
// clipped to the scanline, a line end flag on rsp_tlast and an image end
// flag on rsp_tuser. Header bytes and non-final pixel bytes give no result.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while idle, as the block does not enforce it. The input
// register feeds the result register on rsp_ through a single decode step,
// which also updates the packet and position state. Throughput: one byte
// per cycle, set by that decode step, while no result stalls on rsp_tready.
// Reset clears the decode state, empties both registers and restores the
// register defaults (3-byte pixels, 1x1 image, run-length mode).
// When rsp_tready is low, the pending result holds and the decode step
// stops, whether or not the next byte gives a result; req_tready falls
// once the input register holds a byte, so one byte waits behind it.
module tga_rle_scanline_decoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [trsd_pkg::BYTE_W-1:0]           req_tdata,   // stream_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [trsd_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // pixel_value, run_length
   output logic                                  rsp_tlast,   // line_end
   output logic                                  rsp_tuser,   // image_end
   input  logic                                  csr_we,
   input  logic [trsd_pkg::IDX_W-1:0]            csr_index,
   input  logic [trsd_pkg::CSR_W-1:0]            csr_wdata
);
   import trsd_pkg::*;

   cfg_type cfg;
   rsp_type rsp;

   trsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   trsd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {rsp.run_length, rsp.pixel_value};
   assign rsp_tlast = rsp.line_end;
   assign rsp_tuser = rsp.image_end;

endmodule

[rtl/trsd_csr.sv]
// configuration register file for the scanline decoder
// depends on trsd_pkg
`timescale 1ns / 1ps

module trsd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [trsd_pkg::IDX_W-1:0]   csr_index,
   input  logic [trsd_pkg::CSR_W-1:0]   csr_wdata,
   output trsd_pkg::cfg_type            cfg
);
   import trsd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_bytes <= 3'd3;
         cfg_ff.line_width  <= 16'd1;
         cfg_ff.line_count  <= 16'd1;
         cfg_ff.rle_enabled <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PIXEL_BYTES: cfg_ff.pixel_bytes <= csr_wdata[2:0];
            REG_LINE_WIDTH:  cfg_ff.line_width  <= csr_wdata;
            REG_LINE_COUNT:  cfg_ff.line_count  <= csr_wdata;
            REG_RLE_ENABLED: cfg_ff.rle_enabled <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/trsd_decode.sv]
// input register, packet/pixel decode with position tracking, result register
// depends on trsd_pkg
`timescale 1ns / 1ps

module trsd_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  trsd_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [trsd_pkg::BYTE_W-1:0]  in_byte,
   output logic                         out_valid,
   input  logic                         out_ready,
   output trsd_pkg::rsp_type            out_rsp
);
   import trsd_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_rsp_ff, out_rsp_in;

   logic [1:0]         phase_ff, phase_in;
   logic [RUN_W-1:0]   packet_left_ff, packet_left_in;
   logic [1:0]         slot_ff, slot_in;
   logic [PIXEL_W-1:0] acc_ff, acc_in;
   logic [DIM_W-1:0]   column_ff, column_in;
   logic [DIM_W-1:0]   row_ff, row_in;

   logic               advance;
   logic               rle, is_hdr, last_byte, emit;
   logic [PIXEL_W-1:0] acc_new, pix;
   logic [RUN_W-1:0]   want;
   logic [DIM_W-1:0]   w, h, left;
   logic [DIM_W:0]     row_inc;
   logic               le, ie;
   logic [RUN_W-1:0]   len;
   logic [RUN_W-1:0]   lit_left;

   assign advance  = in_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         in_byte_ff <= in_byte;
      end
   end

   // pixel assembly
   always_comb begin
      rle     = cfg.rle_enabled;
      is_hdr  = rle && (phase_ff != PH_RUN) && (phase_ff != PH_LIT);
      acc_new = acc_ff;
      unique case (slot_ff)
         2'd0: acc_new[7:0]   = acc_ff[7:0]   | in_byte_ff;
         2'd1: acc_new[15:8]  = acc_ff[15:8]  | in_byte_ff;
         2'd2: acc_new[23:16] = acc_ff[23:16] | in_byte_ff;
         2'd3: acc_new[31:24] = acc_ff[31:24] | in_byte_ff;
         default: ;
      endcase
      if (cfg.pixel_bytes == 3'd4) begin
         last_byte = (slot_ff == 2'd3);
         pix       = acc_new;
      end else begin
         last_byte = (slot_ff >= 2'd2);
         pix       = {8'd0, acc_new[23:0]};
      end
      emit = !is_hdr && last_byte;
      if (rle && (phase_ff == PH_RUN)) begin
         want = (packet_left_ff != '0) ? packet_left_ff : RUN_W'(1);
      end else begin
         want = RUN_W'(1);
      end
   end

   // run clipping against the scanline
   always_comb begin
      w       = (cfg.line_width != '0) ? cfg.line_width : DIM_W'(1);
      h       = (cfg.line_count != '0) ? cfg.line_count : DIM_W'(1);
      left    = (column_ff < w) ? (w - column_ff) : DIM_W'(1);
      le      = ({8'd0, want} >= left);
      len     = le ? left[RUN_W-1:0] : want;
      row_inc = {1'b0, row_ff} + (DIM_W+1)'(1);
      ie      = le && (row_inc >= {1'b0, h});
      lit_left = (packet_left_ff != '0) ? (packet_left_ff - RUN_W'(1)) : '0;
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      slot_in        = slot_ff;
      acc_in         = acc_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      if (is_hdr) begin
         if (in_byte_ff[7]) begin
            phase_in       = PH_RUN;
            packet_left_in = in_byte_ff - HDR_RUN_BIAS;
         end else begin
            phase_in       = PH_LIT;
            packet_left_in = in_byte_ff + RUN_W'(1);
         end
         slot_in = '0;
         acc_in  = '0;
      end else if (!last_byte) begin
         acc_in  = acc_new;
         slot_in = slot_ff + 2'd1;
      end else begin
         slot_in = '0;
         acc_in  = '0;
         if (rle) begin
            if (phase_ff == PH_RUN) begin
               phase_in       = PH_HEADER;
               packet_left_in = '0;
            end else begin
               packet_left_in = lit_left;
               if (lit_left == '0) begin
                  phase_in = PH_HEADER;
               end
            end
         end
         if (le) begin
            column_in      = '0;
            row_in         = ie ? '0 : row_inc[DIM_W-1:0];
            phase_in       = PH_HEADER;
            packet_left_in = '0;
         end else begin
            column_in = column_ff + {8'd0, len};
         end
      end
   end

   always_comb begin
      out_rsp_in.pixel_value = pix;
      out_rsp_in.run_length  = len;
      out_rsp_in.line_end    = le;
      out_rsp_in.image_end   = ie;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         packet_left_ff <= '0;
         slot_ff        <= '0;
         acc_ff         <= '0;
         column_ff      <= '0;
         row_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff       <= phase_in;
            packet_left_ff <= packet_left_in;
            slot_ff        <= slot_in;
            acc_ff         <= acc_in;
            column_ff      <= column_in;
            row_ff         <= row_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (advance && emit) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule
